// ===== design/fscr_pkg.sv =====
// Package for the fan serial command responder.
// Holds the command codes, reply constants and the word types shared by the top level and the testbench.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fscr_pkg;

	// Operation carried by an input word.
	localparam logic OP_RX_BYTE = 1'b0;
	localparam logic OP_TX_DONE = 1'b1;

	// Command code ranges.
	localparam logic [7:0] CMD_TEMP_A     = 8'd1;
	localparam logic [7:0] CMD_TEMP_B     = 8'd2;
	localparam logic [7:0] CMD_SPEED_LO   = 8'd3;
	localparam logic [7:0] CMD_SPEED_HI   = 8'd6;
	localparam logic [7:0] CMD_DUTY_LO    = 8'd7;
	localparam logic [7:0] CMD_DUTY_HI    = 8'd10;
	localparam logic [7:0] CMD_ENABLE_LO  = 8'd15;
	localparam logic [7:0] CMD_ENABLE_HI  = 8'd18;
	localparam logic [7:0] CMD_DISABLE_LO = 8'd19;
	localparam logic [7:0] CMD_DISABLE_HI = 8'd22;

	// Acknowledge byte sent after a fan action.
	localparam logic [7:0] OK_CODE = 8'd255;

	// Collection count at which further bytes are ignored.
	localparam logic [1:0] RX_COUNT_MAX = 2'd2;

	typedef enum logic [1:0] {
		FAN_NONE = 2'd0,
		FAN_SET  = 2'd1,
		FAN_ON   = 2'd2,
		FAN_OFF  = 2'd3
	} fan_action_t;

	typedef struct packed {
		logic        op;
		logic [7:0]  rx_byte;
		logic [7:0]  temp_a;
		logic [7:0]  temp_b;
		logic [15:0] speed_a;
		logic [15:0] speed_b;
		logic [15:0] speed_c;
		logic [15:0] speed_d;
	} cmd_word_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		fan_action_t fan_action;
		logic [1:0]  fan_index;
		logic [7:0]  duty_value;
	} rsp_word_t;

endpackage

`default_nettype wire

// ===== design/fscr_cmd_if.sv =====
// Input channel of the fan serial command responder: valid, ready and the input word.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps
`default_nettype none

interface fscr_cmd_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [7:0]  rx_byte;
	logic [7:0]  temp_a;
	logic [7:0]  temp_b;
	logic [15:0] speed_a;
	logic [15:0] speed_b;
	logic [15:0] speed_c;
	logic [15:0] speed_d;

	modport source (
		output valid, op, rx_byte, temp_a, temp_b, speed_a, speed_b, speed_c, speed_d,
		input  ready
	);
	modport sink (
		input  valid, op, rx_byte, temp_a, temp_b, speed_a, speed_b, speed_c, speed_d,
		output ready
	);
endinterface

`default_nettype wire

// ===== design/fscr_rsp_if.sv =====
// Output channel of the fan serial command responder: valid, ready and the result word.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps
`default_nettype none

interface fscr_rsp_if;
	logic       valid;
	logic       ready;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic [1:0] fan_action;
	logic [1:0] fan_index;
	logic [7:0] duty_value;

	modport source (
		output valid, tx_valid, tx_byte, fan_action, fan_index, duty_value,
		input  ready
	);
	modport sink (
		input  valid, tx_valid, tx_byte, fan_action, fan_index, duty_value,
		output ready
	);
endinterface

`default_nettype wire

// ===== design/fan_serial_command_responder.sv =====
// Each accepted word passes through the input register and then the result register, which holds its result word.
// Throughput: one word per cycle; the input register and the result register advance
// together whenever the result register is empty or being taken.
// Reset (arst_n low, asynchronous): both registers empty, command, argument, collection
// count and reply state cleared to zero.
// Top level of the fan serial command responder; uses fscr_pkg and the two channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module fan_serial_command_responder (
	input  wire logic  clk,
	input  wire logic  arst_n,
	fscr_cmd_if.sink   cmd,
	fscr_rsp_if.source rsp
);

	fscr_pkg::cmd_word_t item_s1;
	logic                valid_s1;
	fscr_pkg::rsp_word_t rsp_q;
	logic                rsp_valid_q;

	logic [7:0] cmd_q;
	logic [7:0] arg_q;
	logic [1:0] rx_count_q;
	logic [7:0] reply_q [2];
	logic [1:0] reply_len_q;
	logic [1:0] reply_pos_q;

	logic [7:0] cmd_d;
	logic [7:0] arg_d;
	logic [1:0] rx_count_d;
	logic [7:0] reply0_d;
	logic [7:0] reply1_d;
	logic [1:0] reply_len_d;
	logic [1:0] reply_pos_d;
	fscr_pkg::rsp_word_t rsp_d;

	logic       advance;
	logic [7:0] cmd_off;
	logic [15:0] speed_sel;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1 <= '{op: cmd.op, rx_byte: cmd.rx_byte, temp_a: cmd.temp_a,
				temp_b: cmd.temp_b, speed_a: cmd.speed_a, speed_b: cmd.speed_b,
				speed_c: cmd.speed_c, speed_d: cmd.speed_d};
		end
	end

	always_comb begin
		unique case (cmd_q[1:0] - 2'd3)
			2'd0:    speed_sel = item_s1.speed_a;
			2'd1:    speed_sel = item_s1.speed_b;
			2'd2:    speed_sel = item_s1.speed_c;
			default: speed_sel = item_s1.speed_d;
		endcase
	end

	always_comb begin
		cmd_d       = cmd_q;
		arg_d       = arg_q;
		rx_count_d  = rx_count_q;
		reply0_d    = reply_q[0];
		reply1_d    = reply_q[1];
		reply_len_d = reply_len_q;
		reply_pos_d = reply_pos_q;
		rsp_d       = '{tx_valid: 1'b0, tx_byte: 8'd0, fan_action: fscr_pkg::FAN_NONE,
			fan_index: 2'd0, duty_value: 8'd0};
		cmd_off     = 8'd0;

		priority if (item_s1.op == fscr_pkg::OP_TX_DONE) begin
			if (reply_pos_q < reply_len_q) begin
				rsp_d.tx_valid = 1'b1;
				rsp_d.tx_byte  = reply_q[reply_pos_q[0]];
				reply_pos_d    = reply_pos_q + 2'd1;
			end else begin
				reply_len_d = 2'd0;
				reply_pos_d = 2'd0;
			end
		end else if (reply_len_q != 2'd0) begin
			// A reply is still pending, so the received byte is dropped.
		end else if (item_s1.rx_byte != 8'd0) begin
			if (rx_count_q == 2'd0) begin
				cmd_d = item_s1.rx_byte;
			end else if (rx_count_q == 2'd1) begin
				arg_d = item_s1.rx_byte;
			end
			if (rx_count_q < fscr_pkg::RX_COUNT_MAX) begin
				rx_count_d = rx_count_q + 2'd1;
			end
		end else begin
			// Terminator: execute the stored command. No reply is pending here, so the
			// first reply byte goes out at once and the position moves to the second.
			rx_count_d = 2'd0;
			priority if (cmd_q == fscr_pkg::CMD_TEMP_A) begin
				reply0_d    = item_s1.temp_a;
				reply_len_d = 2'd1;
			end else if (cmd_q == fscr_pkg::CMD_TEMP_B) begin
				reply0_d    = item_s1.temp_b;
				reply_len_d = 2'd1;
			end else if (cmd_q >= fscr_pkg::CMD_SPEED_LO && cmd_q <= fscr_pkg::CMD_SPEED_HI) begin
				reply0_d    = speed_sel[15:8];
				reply1_d    = speed_sel[7:0];
				reply_len_d = 2'd2;
			end else if (cmd_q >= fscr_pkg::CMD_DUTY_LO && cmd_q <= fscr_pkg::CMD_DUTY_HI) begin
				cmd_off          = cmd_q - fscr_pkg::CMD_DUTY_LO;
				rsp_d.fan_action = fscr_pkg::FAN_SET;
				rsp_d.fan_index  = cmd_off[1:0];
				rsp_d.duty_value = arg_q;
				reply0_d         = fscr_pkg::OK_CODE;
				reply_len_d      = 2'd1;
			end else if (cmd_q >= fscr_pkg::CMD_ENABLE_LO &&
					cmd_q <= fscr_pkg::CMD_ENABLE_HI) begin
				cmd_off          = cmd_q - fscr_pkg::CMD_ENABLE_LO;
				rsp_d.fan_action = fscr_pkg::FAN_ON;
				rsp_d.fan_index  = cmd_off[1:0];
				reply0_d         = fscr_pkg::OK_CODE;
				reply_len_d      = 2'd1;
			end else if (cmd_q >= fscr_pkg::CMD_DISABLE_LO &&
					cmd_q <= fscr_pkg::CMD_DISABLE_HI) begin
				cmd_off          = cmd_q - fscr_pkg::CMD_DISABLE_LO;
				rsp_d.fan_action = fscr_pkg::FAN_OFF;
				rsp_d.fan_index  = cmd_off[1:0];
				reply0_d         = fscr_pkg::OK_CODE;
				reply_len_d      = 2'd1;
			end else begin
				// Unknown command: no reply and no action.
			end
			if (reply_len_d != 2'd0) begin
				rsp_d.tx_valid = 1'b1;
				rsp_d.tx_byte  = reply0_d;
				reply_pos_d    = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q       <= 8'd0;
			arg_q       <= 8'd0;
			rx_count_q  <= 2'd0;
			reply_q[0]  <= 8'd0;
			reply_q[1]  <= 8'd0;
			reply_len_q <= 2'd0;
			reply_pos_q <= 2'd0;
		end else if (advance) begin
			cmd_q       <= cmd_d;
			arg_q       <= arg_d;
			rx_count_q  <= rx_count_d;
			reply_q[0]  <= reply0_d;
			reply_q[1]  <= reply1_d;
			reply_len_q <= reply_len_d;
			reply_pos_q <= reply_pos_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.tx_valid   = rsp_q.tx_valid;
	assign rsp.tx_byte    = rsp_q.tx_byte;
	assign rsp.fan_action = rsp_q.fan_action;
	assign rsp.fan_index  = rsp_q.fan_index;
	assign rsp.duty_value = rsp_q.duty_value;

endmodule

`default_nettype wire

// ===== design/fscr_checker.sv =====
// Port-level checks for the fan serial command responder, bound to the top level.
// Depends on fscr_pkg and on the top level's channel ports.
`timescale 1ns / 1ps
`default_nettype none

module fscr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic       tx_valid,
	input wire logic [7:0] tx_byte,
	input wire logic [1:0] fan_action,
	input wire logic [1:0] fan_index,
	input wire logic [7:0] duty_value
);

	// A stalled result word stays valid and keeps its transmit byte and fan action.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(tx_byte) && $stable(fan_action))
		else $error("result word changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !tx_valid |-> tx_byte == 8'd0)
		else $error("tx_byte nonzero without a transmission");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && fan_action == 2'(fscr_pkg::FAN_NONE) |-> fan_index == 2'd0)
		else $error("fan_index set without a fan action");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && fan_action != 2'(fscr_pkg::FAN_SET) |-> duty_value == 8'd0)
		else $error("duty_value set outside a set-duty action");

	// Every fan action is acknowledged in the same word.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && fan_action != 2'(fscr_pkg::FAN_NONE)
			|-> tx_valid && tx_byte == fscr_pkg::OK_CODE)
		else $error("fan action without acknowledge byte");

endmodule

bind fan_serial_command_responder fscr_checker u_fscr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.tx_valid   (rsp.tx_valid),
	.tx_byte    (rsp.tx_byte),
	.fan_action (rsp.fan_action),
	.fan_index  (rsp.fan_index),
	.duty_value (rsp.duty_value)
);

`default_nettype wire

// ===== tb/fan_serial_command_responder_test.sv =====
// Self-checking testbench for the fan serial command responder.
// Depends on fscr_pkg, the fscr_cmd_if and fscr_rsp_if channel interfaces and the top level.
// Directed command sequences come first, then random traffic, checked against a local model.
`timescale 1ns / 1ps

module fan_serial_command_responder_test;

	logic clk;
	logic arst_n;

	fscr_cmd_if cmd_ch ();
	fscr_rsp_if rsp_ch ();

	fan_serial_command_responder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// Local copy of the responder state.
	logic [7:0] cur_cmd;
	logic [7:0] cur_arg;
	logic [1:0] collected;
	logic [7:0] pend_bytes [2];
	logic [1:0] pend_len;
	logic [1:0] pend_sent;

	fscr_pkg::rsp_word_t expected_replies [$];
	int                  err_count;
	int                  words_sent;
	bit                  gaps_on;

	always #5 clk = ~clk;

	// Push a reply byte, up to two of them.
	function void queue_reply(input logic [7:0] b);
		if (pend_len < 2'd2) begin
			pend_bytes[pend_len[0]] = b;
			pend_len = pend_len + 2'd1;
		end
	endfunction

	// Transmit the next pending byte, or clear the reply when none is left.
	function void advance_reply(inout fscr_pkg::rsp_word_t r);
		if (pend_sent < pend_len && pend_sent < 2'd2) begin
			r.tx_valid = 1'b1;
			r.tx_byte  = pend_bytes[pend_sent[0]];
			pend_sent  = pend_sent + 2'd1;
		end else begin
			pend_len  = 2'd0;
			pend_sent = 2'd0;
		end
	endfunction

	function fscr_pkg::rsp_word_t compute_reply(input fscr_pkg::cmd_word_t w);
		fscr_pkg::rsp_word_t r;
		logic [7:0]          code;
		logic [7:0]          offs;
		logic [15:0]         spd;
		r = '0;
		if (w.op == fscr_pkg::OP_TX_DONE) begin
			advance_reply(r);
			return r;
		end
		// Received words are swallowed while a reply is still going out.
		if (pend_len != 2'd0)
			return r;
		if (w.rx_byte != 8'd0) begin
			if (collected == 2'd0)
				cur_cmd = w.rx_byte;
			else if (collected == 2'd1)
				cur_arg = w.rx_byte;
			if (collected < fscr_pkg::RX_COUNT_MAX)
				collected = collected + 2'd1;
			return r;
		end
		code = cur_cmd;
		if (code == fscr_pkg::CMD_TEMP_A) begin
			queue_reply(w.temp_a);
		end else if (code == fscr_pkg::CMD_TEMP_B) begin
			queue_reply(w.temp_b);
		end else if (code >= fscr_pkg::CMD_SPEED_LO && code <= fscr_pkg::CMD_SPEED_HI) begin
			offs = code - fscr_pkg::CMD_SPEED_LO;
			case (offs[1:0])
				2'd0: spd = w.speed_a;
				2'd1: spd = w.speed_b;
				2'd2: spd = w.speed_c;
				default: spd = w.speed_d;
			endcase
			queue_reply(spd[15:8]);
			queue_reply(spd[7:0]);
		end else if (code >= fscr_pkg::CMD_DUTY_LO && code <= fscr_pkg::CMD_DUTY_HI) begin
			offs = code - fscr_pkg::CMD_DUTY_LO;
			r.fan_action = fscr_pkg::FAN_SET;
			r.fan_index  = offs[1:0];
			r.duty_value = cur_arg;
			queue_reply(fscr_pkg::OK_CODE);
		end else if (code >= fscr_pkg::CMD_ENABLE_LO && code <= fscr_pkg::CMD_ENABLE_HI) begin
			offs = code - fscr_pkg::CMD_ENABLE_LO;
			r.fan_action = fscr_pkg::FAN_ON;
			r.fan_index  = offs[1:0];
			queue_reply(fscr_pkg::OK_CODE);
		end else if (code >= fscr_pkg::CMD_DISABLE_LO && code <= fscr_pkg::CMD_DISABLE_HI) begin
			offs = code - fscr_pkg::CMD_DISABLE_LO;
			r.fan_action = fscr_pkg::FAN_OFF;
			r.fan_index  = offs[1:0];
			queue_reply(fscr_pkg::OK_CODE);
		end
		collected = 2'd0;
		advance_reply(r);
		return r;
	endfunction

	// Sensor readings lean towards their extremes now and then.
	function logic [7:0] rand_reading8();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return 8'd0;
		if (pick == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	function logic [15:0] rand_reading16();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return 16'd0;
		if (pick == 1)
			return 16'hFFFF;
		return 16'($urandom_range(0, 65535));
	endfunction

	function fscr_pkg::cmd_word_t make_word(input logic op, input logic [7:0] rx);
		fscr_pkg::cmd_word_t w;
		w.op      = op;
		w.rx_byte = rx;
		w.temp_a  = rand_reading8();
		w.temp_b  = rand_reading8();
		w.speed_a = rand_reading16();
		w.speed_b = rand_reading16();
		w.speed_c = rand_reading16();
		w.speed_d = rand_reading16();
		return w;
	endfunction

	// Valid stays high after acceptance until the next falling edge that this task
	// or hold_input reaches, so it is never lowered and raised in the same step.
	task send_word(input fscr_pkg::cmd_word_t w);
		int gap;
		gap = gaps_on ? $urandom_range(0, 9) : 0;
		@(negedge clk);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.op      <= w.op;
		cmd_ch.rx_byte <= w.rx_byte;
		cmd_ch.temp_a  <= w.temp_a;
		cmd_ch.temp_b  <= w.temp_b;
		cmd_ch.speed_a <= w.speed_a;
		cmd_ch.speed_b <= w.speed_b;
		cmd_ch.speed_c <= w.speed_c;
		cmd_ch.speed_d <= w.speed_d;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		expected_replies.push_back(compute_reply(w));
		words_sent++;
	endtask

	task send_op(input logic op, input logic [7:0] rx);
		send_word(make_word(op, rx));
	endtask

	// Keep signalling transmit-done until the pending reply has cleared.
	task finish_reply();
		while (pend_len != 2'd0)
			send_op(fscr_pkg::OP_TX_DONE, 8'($urandom_range(0, 255)));
	endtask

	// Stop sending and wait until every expected result word has arrived.
	task hold_input();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
	endtask

	task test_idle_after_reset();
		send_op(fscr_pkg::OP_TX_DONE, 8'hFF);
		// Command zero executes nothing.
		send_op(fscr_pkg::OP_RX_BYTE, 8'd0);
	endtask

	task test_temperature_reply();
		fscr_pkg::cmd_word_t w;
		send_op(fscr_pkg::OP_RX_BYTE, fscr_pkg::CMD_TEMP_A);
		w = make_word(fscr_pkg::OP_RX_BYTE, 8'd0);
		w.temp_a = 8'hFF;
		send_word(w);
		finish_reply();
	endtask

	task test_speed_reply_and_drop();
		fscr_pkg::cmd_word_t w;
		send_op(fscr_pkg::OP_RX_BYTE, fscr_pkg::CMD_SPEED_HI);
		w = make_word(fscr_pkg::OP_RX_BYTE, 8'd0);
		w.speed_d = 16'h80FF;
		send_word(w);
		// Both of these are dropped while the reply is pending, the terminator too.
		send_op(fscr_pkg::OP_RX_BYTE, fscr_pkg::CMD_TEMP_B);
		send_op(fscr_pkg::OP_RX_BYTE, 8'd0);
		finish_reply();
	endtask

	task test_fan_commands();
		send_op(fscr_pkg::OP_RX_BYTE, fscr_pkg::CMD_DUTY_LO);
		send_op(fscr_pkg::OP_RX_BYTE, 8'hFF);
		// A third byte is ignored by the collection.
		send_op(fscr_pkg::OP_RX_BYTE, fscr_pkg::CMD_DISABLE_HI);
		send_op(fscr_pkg::OP_RX_BYTE, 8'd0);
		finish_reply();
		// A bare terminator reruns the stale command and argument.
		send_op(fscr_pkg::OP_RX_BYTE, 8'd0);
		finish_reply();
		send_op(fscr_pkg::OP_RX_BYTE, fscr_pkg::CMD_ENABLE_HI);
		send_op(fscr_pkg::OP_RX_BYTE, 8'd0);
		finish_reply();
		send_op(fscr_pkg::OP_RX_BYTE, fscr_pkg::CMD_DISABLE_HI);
		send_op(fscr_pkg::OP_RX_BYTE, 8'd0);
		finish_reply();
	endtask

	task test_silent_command();
		send_op(fscr_pkg::OP_RX_BYTE, 8'd11);
		send_op(fscr_pkg::OP_RX_BYTE, 8'd0);
		send_op(fscr_pkg::OP_TX_DONE, 8'd0);
	endtask

	task test_random_traffic(input int count);
		int         stop_at;
		int         n_extra;
		logic [7:0] code;
		stop_at = words_sent + count;
		while (words_sent < stop_at) begin
			if ($urandom_range(0, 19) == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 39) == 0)
				hold_input();
			if ($urandom_range(0, 99) < 80) begin
				// Mostly well-formed command: usually a code and an argument, sometimes extra bytes, a terminator, then the reply.
				if ($urandom_range(0, 9) < 8)
					code = 8'($urandom_range(1, 22));
				else
					code = 8'($urandom_range(1, 255));
				if ($urandom_range(0, 9) != 0)
					send_op(fscr_pkg::OP_RX_BYTE, code);
				if ($urandom_range(0, 9) < 8)
					send_op(fscr_pkg::OP_RX_BYTE, 8'($urandom_range(1, 255)));
				n_extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
				repeat (n_extra)
					send_op(fscr_pkg::OP_RX_BYTE, 8'($urandom_range(1, 255)));
				send_op(fscr_pkg::OP_RX_BYTE, 8'd0);
				while (pend_len != 2'd0) begin
					if ($urandom_range(0, 4) == 0)
						send_op(fscr_pkg::OP_RX_BYTE, ($urandom_range(0, 2) == 0) ? 8'd0 :
							8'($urandom_range(1, 255)));
					else
						send_op(fscr_pkg::OP_TX_DONE, 8'($urandom_range(0, 255)));
				end
			end else begin
				repeat ($urandom_range(1, 5))
					send_op(1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0) ? 8'd0 :
						8'($urandom_range(1, 255)));
			end
		end
	endtask

	// Result side: a random stall before each word is taken while gaps are on.
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = gaps_on ? $urandom_range(0, 9) : 0;
			@(negedge clk);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(rsp_ch.valid && rsp_ch.ready));
		end
	end

	always @(posedge clk) begin
		fscr_pkg::rsp_word_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_replies.size() == 0) begin
				$error("result word with nothing expected");
				err_count++;
			end else begin
				want = expected_replies.pop_front();
				if (rsp_ch.tx_valid !== want.tx_valid) begin
					$error("tx_valid: expected %0d, got %0d", want.tx_valid, rsp_ch.tx_valid);
					err_count++;
				end
				if (rsp_ch.tx_byte !== want.tx_byte) begin
					$error("tx_byte: expected %0d, got %0d", want.tx_byte, rsp_ch.tx_byte);
					err_count++;
				end
				if (rsp_ch.fan_action !== want.fan_action) begin
					$error("fan_action: expected %0d, got %0d", want.fan_action,
						rsp_ch.fan_action);
					err_count++;
				end
				if (rsp_ch.fan_index !== want.fan_index) begin
					$error("fan_index: expected %0d, got %0d", want.fan_index,
						rsp_ch.fan_index);
					err_count++;
				end
				if (rsp_ch.duty_value !== want.duty_value) begin
					$error("duty_value: expected %0d, got %0d", want.duty_value,
						rsp_ch.duty_value);
					err_count++;
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.op      = fscr_pkg::OP_RX_BYTE;
		cmd_ch.rx_byte = 8'd0;
		cmd_ch.temp_a  = 8'd0;
		cmd_ch.temp_b  = 8'd0;
		cmd_ch.speed_a = 16'd0;
		cmd_ch.speed_b = 16'd0;
		cmd_ch.speed_c = 16'd0;
		cmd_ch.speed_d = 16'd0;
		cur_cmd        = 8'd0;
		cur_arg        = 8'd0;
		collected      = 2'd0;
		pend_bytes[0]  = 8'd0;
		pend_bytes[1]  = 8'd0;
		pend_len       = 2'd0;
		pend_sent      = 2'd0;
		err_count      = 0;
		words_sent     = 0;
		gaps_on        = 1'b1;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_idle_after_reset();
		test_temperature_reply();
		test_speed_reply_and_drop();
		test_fan_commands();
		test_silent_command();
		hold_input();
		test_random_traffic(1000);

		hold_input();
		repeat (5) @(posedge clk);
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
